/* design/spa_pkg.sv */
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types, constants and primitive tables of the stroke primitive
// assembler.
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 4;
   localparam int IN_BITS    = 20;
   localparam int OUT_BITS   = 16;
   localparam int COLOR_BITS = 32;
   localparam int DIM_BITS   = 15;
   localparam int STYLE_BITS = 6;
   localparam int NUM_SLOTS  = 4;
   localparam int SLOT_BITS  = 2;
   localparam int NUM_KINDS  = 10;
   localparam int KIND_BITS  = 4;
   localparam int VCNT_BITS  = 3;

   localparam int    HALF_LSB  = (1 << FRAC_BITS) >> 1;
   localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
   localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

   localparam int STYLE_OUTLINE  = 0;
   localparam int STYLE_FILL     = 1;
   localparam int STYLE_INLINE   = 2;
   localparam int STYLE_INNER    = 3;
   localparam int STYLE_DIAGONAL = 4;
   localparam int STYLE_RADIAL   = 5;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCREEN_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_COLOR_BYTE_SWAP = 2'd2;

   localparam logic [DIM_BITS-1:0] RESET_SCREEN_WIDTH  = 15'd640;
   localparam logic [DIM_BITS-1:0] RESET_SCREEN_HEIGHT = 15'd480;

   localparam logic [KIND_BITS-1:0] KIND_QUAD  = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_TRI_A = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_TRI_B = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_L02   = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_L31   = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_L12   = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_L03   = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_L01   = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_L23   = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_P0    = 4'd9;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] screen_width;
      logic [DIM_BITS-1:0] screen_height;
      logic                color_byte_swap;
   } cfg_type;

   typedef struct packed {
      point_type [NUM_SLOTS-1:0] pts;
      logic [NUM_KINDS-1:0]      kinds;
      logic [COLOR_BITS-1:0]     color;
   } job_type;

   typedef struct packed {
      logic [VCNT_BITS-1:0]                 n;
      logic [NUM_SLOTS-1:0][SLOT_BITS-1:0] slot;
   } shape_type;

   typedef struct packed {
      logic [VCNT_BITS-1:0]                vertex_count;
      logic [NUM_SLOTS-1:0][OUT_BITS-1:0] vx;
      logic [NUM_SLOTS-1:0][OUT_BITS-1:0] vy;
      logic [COLOR_BITS-1:0]               color;
      logic                                run_last;
   } prim_type;

   function automatic logic [NUM_KINDS-1:0] kind_enable(input logic [STYLE_BITS-1:0] style);
      logic [NUM_KINDS-1:0] m;
      m = '0;
      if (style[STYLE_OUTLINE]) begin
         if (style[STYLE_FILL]) begin
            if (style[STYLE_INLINE]) m[KIND_QUAD] = 1'b1;
            else if (style[STYLE_INNER]) m[KIND_TRI_A] = 1'b1;
            else if (style[STYLE_DIAGONAL]) m[KIND_TRI_B] = 1'b1;
            else m[KIND_TRI_A] = 1'b1;
         end else begin
            m[KIND_L02] = 1'b1;
            m[KIND_L31] = style[STYLE_INLINE];
            m[KIND_L12] = style[STYLE_INNER];
            m[KIND_L03] = style[STYLE_DIAGONAL];
            m[KIND_L01] = style[STYLE_RADIAL];
            m[KIND_L23] = style[STYLE_RADIAL];
         end
      end else if (style[STYLE_RADIAL]) begin
         m[KIND_L01] = 1'b1;
      end else begin
         m[KIND_P0] = 1'b1;
      end
      return m;
   endfunction

   function automatic shape_type kind_shape(input logic [KIND_BITS-1:0] k);
      shape_type s;
      s = '0;
      case (k)
         KIND_QUAD: begin
            s.n = 3'd4;
            s.slot[0] = 2'd0; s.slot[1] = 2'd2; s.slot[2] = 2'd3; s.slot[3] = 2'd1;
         end
         KIND_TRI_A: begin
            s.n = 3'd3;
            s.slot[0] = 2'd0; s.slot[1] = 2'd2; s.slot[2] = 2'd3;
         end
         KIND_TRI_B: begin
            s.n = 3'd3;
            s.slot[0] = 2'd0; s.slot[1] = 2'd2; s.slot[2] = 2'd1;
         end
         KIND_L02: begin
            s.n = 3'd2; s.slot[0] = 2'd0; s.slot[1] = 2'd2;
         end
         KIND_L31: begin
            s.n = 3'd2; s.slot[0] = 2'd3; s.slot[1] = 2'd1;
         end
         KIND_L12: begin
            s.n = 3'd2; s.slot[0] = 2'd1; s.slot[1] = 2'd2;
         end
         KIND_L03: begin
            s.n = 3'd2; s.slot[0] = 2'd0; s.slot[1] = 2'd3;
         end
         KIND_L01: begin
            s.n = 3'd2; s.slot[0] = 2'd0; s.slot[1] = 2'd1;
         end
         KIND_L23: begin
            s.n = 3'd2; s.slot[0] = 2'd2; s.slot[1] = 2'd3;
         end
         default: begin
            s.n = 3'd1; s.slot[0] = 2'd0;
         end
      endcase
      return s;
   endfunction

endpackage

/* design/spa_front.sv */
// ----------------------------------------------------------------------------
// spa_front
// Accepts points, rounds them, keeps the four-point window and the set phase,
// and queues a job with the surviving primitive kinds when a pair completes.
// ----------------------------------------------------------------------------
module spa_front
   import spa_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  cfg_type                      cfg,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [IN_BITS-1:0]    req_x_coord,
   input  logic signed [IN_BITS-1:0]    req_y_coord,
   input  logic                         req_set_start,
   input  logic                         req_set_end,
   input  logic [STYLE_BITS-1:0]        req_style_bits,
   input  logic [COLOR_BITS-1:0]        req_color_in,
   input  logic                         job_full,
   output logic                         job_push,
   output job_type                      job
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_EVEN = 2'd2;
   localparam logic [1:0] PH_ODD  = 2'd3;

   function automatic logic signed [COORD_BITS-1:0] round_coord(
      input logic signed [IN_BITS-1:0] v);
      logic [IN_BITS:0]        mag;
      logic [IN_BITS:0]        q;
      logic signed [IN_BITS+1:0] r;
      logic signed [63:0]      rw;
      if (v[IN_BITS-1]) mag = ~{v[IN_BITS-1], v} + (IN_BITS+1)'(1);
      else mag = {1'b0, v};
      q = (mag + (IN_BITS+1)'(HALF_LSB)) >> FRAC_BITS;
      r = $signed({1'b0, q});
      if (v[IN_BITS-1]) r = -r;
      rw = 64'(r);
      if (rw > COORD_MAX) rw = COORD_MAX;
      if (rw < COORD_MIN) rw = COORD_MIN;
      return COORD_BITS'(rw);
   endfunction

   point_type [NUM_SLOTS-1:0] win_ff, win_in;
   logic [1:0]                phase_ff, phase_in;
   logic                      accept;
   logic                      start_eff;
   logic                      build;
   point_type                 pt;
   logic [NUM_SLOTS-1:0]      onscr;
   logic [NUM_KINDS-1:0]      hits;
   logic [NUM_KINDS-1:0]      enables;
   shape_type                 sh;
   logic [COLOR_BITS-1:0]     color;

   assign accept    = req_push && !job_full;
   assign req_full  = job_full;
   assign start_eff = req_set_start || (phase_ff == PH_IDLE);

   always_comb begin
      pt.x     = round_coord(req_x_coord);
      pt.y     = round_coord(req_y_coord);
      win_in   = win_ff;
      phase_in = phase_ff;
      build    = 1'b0;
      if (start_eff) begin
         win_in[2] = pt;
         phase_in  = PH_ONE;
      end else begin
         case (phase_ff)
            PH_ONE: begin
               win_in[3] = pt;
               phase_in  = PH_EVEN;
            end
            PH_EVEN: begin
               win_in    = {pt, win_ff[3], win_ff[2], win_ff[1]};
               phase_in  = PH_ODD;
               build     = req_set_end;
            end
            default: begin
               win_in    = {pt, win_ff[3], win_ff[2], win_ff[1]};
               phase_in  = PH_EVEN;
               build     = 1'b1;
            end
         endcase
      end
      if (req_set_end) phase_in = PH_IDLE;
   end

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         onscr[i] = !win_in[i].x[COORD_BITS-1] && !win_in[i].y[COORD_BITS-1] &&
                    (32'($unsigned(win_in[i].x)) < 32'(cfg.screen_width)) &&
                    (32'($unsigned(win_in[i].y)) < 32'(cfg.screen_height));
      end
      enables = kind_enable(req_style_bits);
      for (int k = 0; k < NUM_KINDS; k++) begin
         sh      = kind_shape(KIND_BITS'(k));
         hits[k] = 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if ((VCNT_BITS'(i) < sh.n) && onscr[sh.slot[i]]) hits[k] = 1'b1;
         end
      end
   end

   always_comb begin
      if (cfg.color_byte_swap) begin
         color = {req_color_in[7:0], req_color_in[15:8],
                  req_color_in[23:16], req_color_in[31:24]};
      end else begin
         color = req_color_in;
      end
   end

   assign job.pts   = win_in;
   assign job.kinds = enables & hits;
   assign job.color = color;
   assign job_push  = accept && build && (job.kinds != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         phase_ff <= PH_IDLE;
      end else if (accept) begin
         win_ff   <= win_in;
         phase_ff <= phase_in;
      end
   end

   a_end_closes_set: assert property (@(posedge clock) disable iff (reset)
      accept && req_set_end |=> phase_ff == PH_IDLE)
      else $error("set phase not cleared after set end");

   a_job_from_pair: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !start_eff && (phase_ff == PH_EVEN || phase_ff == PH_ODD))
      else $error("job queued outside a point pair");

endmodule

/* design/spa_job_queue.sv */
// ----------------------------------------------------------------------------
// spa_job_queue
// Two-entry queue of primitive jobs between the front and the back.
// ----------------------------------------------------------------------------
module spa_job_queue
   import spa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output job_type pop_data
);

   job_type [1:0] entry_ff;
   logic          wr_ff;
   logic          rd_ff;
   logic [1:0]    count_ff;
   logic          do_push;
   logic          do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = entry_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

/* design/spa_back.sv */
// ----------------------------------------------------------------------------
// spa_back
// Walks the surviving primitive kinds of one job, one per cycle while the
// result queue has room, merges repeated vertices and queues each primitive.
// ----------------------------------------------------------------------------
module spa_back
   import spa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  job,
   output logic     job_pop,
   input  logic     rsp_pop,
   output logic     rsp_empty,
   output prim_type rsp_prim
);

   job_type              cur_ff, cur_in;
   logic                 busy_ff, busy_in;
   logic [NUM_KINDS-1:0] rem_ff, rem_in;
   logic [NUM_KINDS-1:0] low;
   logic [NUM_KINDS-1:0] rem_next;
   logic [KIND_BITS-1:0] kind;
   logic                 last;
   logic                 emit;
   logic                 oq_room;
   logic                 oq_pop;
   prim_type             prim_in;
   prim_type [1:0]       oq_ff;
   logic                 oq_wr_ff;
   logic                 oq_rd_ff;
   logic [1:0]           oq_cnt_ff;
   shape_type            sh;
   point_type [NUM_SLOTS-1:0] v;
   logic [NUM_SLOTS-1:0] keep;
   logic [VCNT_BITS-1:0] m;

   assign oq_pop    = rsp_pop && (oq_cnt_ff != 2'd0);
   assign oq_room   = (oq_cnt_ff != 2'd2) || rsp_pop;
   assign emit      = busy_ff && oq_room;
   assign low       = rem_ff & (~rem_ff + NUM_KINDS'(1));
   assign rem_next  = rem_ff & ~low;
   assign last      = (rem_next == '0);
   assign job_pop   = job_valid && (!busy_ff || (emit && last));
   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_prim  = oq_ff[oq_rd_ff];

   always_comb begin
      kind = '0;
      for (int k = NUM_KINDS - 1; k >= 0; k--) begin
         if (low[k]) kind = KIND_BITS'(k);
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      if (job_pop) begin
         cur_in  = job;
         busy_in = 1'b1;
         rem_in  = job.kinds;
      end else if (emit) begin
         busy_in = !last;
         rem_in  = rem_next;
      end
   end

   always_comb begin
      sh = kind_shape(kind);
      for (int i = 0; i < NUM_SLOTS; i++) v[i] = cur_ff.pts[sh.slot[i]];
      keep[0] = 1'b1;
      for (int i = 1; i < NUM_SLOTS; i++) begin
         keep[i] = (VCNT_BITS'(i) < sh.n) && (v[i] != v[i-1]);
      end
      prim_in    = '0;
      m          = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (keep[i]) begin
            prim_in.vx[m[SLOT_BITS-1:0]] = OUT_BITS'(v[i].x);
            prim_in.vy[m[SLOT_BITS-1:0]] = OUT_BITS'(v[i].y);
            m = m + VCNT_BITS'(1);
         end
      end
      prim_in.vertex_count = m;
      prim_in.color        = cur_ff.color;
      prim_in.run_last     = last;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) oq_ff[oq_wr_ff] <= prim_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rem_ff    <= '0;
         oq_wr_ff  <= 1'b0;
         oq_rd_ff  <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         busy_ff   <= busy_in;
         rem_ff    <= rem_in;
         if (emit) oq_wr_ff <= !oq_wr_ff;
         if (oq_pop) oq_rd_ff <= !oq_rd_ff;
         oq_cnt_ff <= oq_cnt_ff + 2'(emit) - 2'(oq_pop);
      end
   end

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff != '0)
      else $error("back busy with no primitive left");

   a_job_not_empty: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job.kinds != '0)
      else $error("job taken without surviving primitives");

   a_vertex_count: assert property (@(posedge clock) disable iff (reset)
      emit |-> prim_in.vertex_count >= 3'd1 && prim_in.vertex_count <= 3'd4)
      else $error("primitive vertex count out of range");

endmodule

/* design/stroke_primitive_assembler.sv */
// ----------------------------------------------------------------------------
// stroke_primitive_assembler
// Assembles polyline points into culled quads, triangles, lines and points.
// ----------------------------------------------------------------------------
// The first primitive of a point passes through the job queue, the back end's
// current-job register and its output queue before it shows on the result port.
// Points are taken one per cycle while the two-job queue is not full; the back
// end issues one primitive per cycle while its output queue has room.
// Reset clears the window, set phase and queues; the screen resets to 640 by 480.
module stroke_primitive_assembler
   import spa_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic signed [IN_BITS-1:0]    req_x_coord,
   input  logic signed [IN_BITS-1:0]    req_y_coord,
   input  logic                         req_set_start,
   input  logic                         req_set_end,
   input  logic [STYLE_BITS-1:0]        req_style_bits,
   input  logic [COLOR_BITS-1:0]        req_color_in,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic [VCNT_BITS-1:0]         rsp_vertex_count,
   output logic signed [OUT_BITS-1:0]   rsp_v0_x,
   output logic signed [OUT_BITS-1:0]   rsp_v0_y,
   output logic signed [OUT_BITS-1:0]   rsp_v1_x,
   output logic signed [OUT_BITS-1:0]   rsp_v1_y,
   output logic signed [OUT_BITS-1:0]   rsp_v2_x,
   output logic signed [OUT_BITS-1:0]   rsp_v2_y,
   output logic signed [OUT_BITS-1:0]   rsp_v3_x,
   output logic signed [OUT_BITS-1:0]   rsp_v3_y,
   output logic [COLOR_BITS-1:0]        rsp_color_out,
   output logic                         rsp_run_last,
   input  logic                         csr_write,
   input  logic [CSR_IDX_BITS-1:0]      csr_index,
   input  logic [DIM_BITS-1:0]          csr_wdata
);

   cfg_type  cfg_ff;
   logic     job_push;
   job_type  job_in;
   logic     job_full;
   logic     job_valid;
   logic     job_pop;
   job_type  job_out;
   prim_type rsp_prim;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width    <= RESET_SCREEN_WIDTH;
         cfg_ff.screen_height   <= RESET_SCREEN_HEIGHT;
         cfg_ff.color_byte_swap <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:    cfg_ff.screen_width    <= csr_wdata;
            CSR_SCREEN_HEIGHT:   cfg_ff.screen_height   <= csr_wdata;
            CSR_COLOR_BYTE_SWAP: cfg_ff.color_byte_swap <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   spa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_set_start  (req_set_start),
      .req_set_end    (req_set_end),
      .req_style_bits (req_style_bits),
      .req_color_in   (req_color_in),
      .job_full       (job_full),
      .job_push       (job_push),
      .job            (job_in)
   );

   spa_job_queue u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .pop_data  (job_out)
   );

   spa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job_out),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_prim  (rsp_prim)
   );

   assign rsp_vertex_count = rsp_prim.vertex_count;
   assign rsp_v0_x         = $signed(rsp_prim.vx[0]);
   assign rsp_v0_y         = $signed(rsp_prim.vy[0]);
   assign rsp_v1_x         = $signed(rsp_prim.vx[1]);
   assign rsp_v1_y         = $signed(rsp_prim.vy[1]);
   assign rsp_v2_x         = $signed(rsp_prim.vx[2]);
   assign rsp_v2_y         = $signed(rsp_prim.vy[2]);
   assign rsp_v3_x         = $signed(rsp_prim.vx[3]);
   assign rsp_v3_y         = $signed(rsp_prim.vy[3]);
   assign rsp_color_out    = rsp_prim.color;
   assign rsp_run_last     = rsp_prim.run_last;

endmodule

/* dv/tb_stroke_primitive_assembler.sv */
// ----------------------------------------------------------------------------
// tb_stroke_primitive_assembler
// Self-checking testbench for the stroke primitive assembler. Points are
// pushed with random gaps, and a scoreboard predicts the culled primitives
// that each accepted request causes. Primitives are popped with random stalls
// and compared field by field, in order, under several screen settings.
// ----------------------------------------------------------------------------
module tb_stroke_primitive_assembler;
   import spa_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_INDEX = 2'd3;

   localparam logic [STYLE_BITS-1:0] M_OUTLINE  = STYLE_BITS'(1 << STYLE_OUTLINE);
   localparam logic [STYLE_BITS-1:0] M_FILL     = STYLE_BITS'(1 << STYLE_FILL);
   localparam logic [STYLE_BITS-1:0] M_INLINE   = STYLE_BITS'(1 << STYLE_INLINE);
   localparam logic [STYLE_BITS-1:0] M_INNER    = STYLE_BITS'(1 << STYLE_INNER);
   localparam logic [STYLE_BITS-1:0] M_DIAGONAL = STYLE_BITS'(1 << STYLE_DIAGONAL);
   localparam logic [STYLE_BITS-1:0] M_RADIAL   = STYLE_BITS'(1 << STYLE_RADIAL);

   typedef enum logic [1:0] {SET_IDLE, SET_ONE, SET_EVEN, SET_ODD} set_phase_type;

   typedef struct packed {
      logic signed [IN_BITS-1:0] x;
      logic signed [IN_BITS-1:0] y;
      logic                      start;
      logic                      stop;
      logic [STYLE_BITS-1:0]     style;
      logic [COLOR_BITS-1:0]     color;
   } point_request_type;

   class stroke_scoreboard_type;
      logic [DIM_BITS-1:0]   screen_w;
      logic [DIM_BITS-1:0]   screen_h;
      logic                  swap;
      point_type             window [NUM_SLOTS];
      set_phase_type         phase;
      prim_type              expected [$];
      logic [COLOR_BITS-1:0] cur_color;
      int                    added;
      int                    mismatches;
      int                    results_seen;

      function new();
         screen_w = RESET_SCREEN_WIDTH;
         screen_h = RESET_SCREEN_HEIGHT;
         swap = 1'b0;
         foreach (window[i]) window[i] = '0;
         phase = SET_IDLE;
         added = 0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void write_register(logic [CSR_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] value);
         case (idx)
            CSR_SCREEN_WIDTH: begin
               screen_w = value;
            end
            CSR_SCREEN_HEIGHT: begin
               screen_h = value;
            end
            CSR_COLOR_BYTE_SWAP: begin
               swap = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      function logic signed [COORD_BITS-1:0] to_pixel(logic signed [IN_BITS-1:0] raw);
         longint v;
         longint r;
         v = longint'(raw);
         if (v >= 0) r = (v + HALF_LSB) >>> FRAC_BITS;
         else r = -((-v + HALF_LSB) >>> FRAC_BITS);
         if (r > COORD_MAX) r = COORD_MAX;
         if (r < COORD_MIN) r = COORD_MIN;
         return r[COORD_BITS-1:0];
      endfunction

      // Culls one primitive given by window slots and queues it if it survives.
      function void add_primitive(int n, int s0, int s1 = 0, int s2 = 0, int s3 = 0);
         int       slots [4];
         int       px;
         int       py;
         int       m;
         int       i;
         bit       visible;
         prim_type p;
         slots = '{s0, s1, s2, s3};
         m = 0;
         visible = 1'b0;
         p = '0;
         for (i = 0; i < n; i++) begin
            px = int'(window[slots[i]].x);
            py = int'(window[slots[i]].y);
            if (px >= 0 && px < int'(screen_w) && py >= 0 && py < int'(screen_h))
               visible = 1'b1;
            if (m > 0 && p.vx[m-1] == window[slots[i]].x && p.vy[m-1] == window[slots[i]].y)
               continue;
            p.vx[m] = window[slots[i]].x;
            p.vy[m] = window[slots[i]].y;
            m++;
         end
         if (visible && m > 0) begin
            p.vertex_count = VCNT_BITS'(m);
            p.color = cur_color;
            expected.insert(expected.size(), p);
            added++;
         end
      endfunction

      function void note_request(point_request_type rq);
         point_type pt;
         bit        fire;
         pt.x = to_pixel(rq.x);
         pt.y = to_pixel(rq.y);
         cur_color = swap ? {rq.color[7:0], rq.color[15:8], rq.color[23:16], rq.color[31:24]}
                          : rq.color;
         fire = 1'b0;
         if (rq.start || phase == SET_IDLE) begin
            window[2] = pt;
            phase = SET_ONE;
         end else if (phase == SET_ONE) begin
            window[3] = pt;
            phase = SET_EVEN;
         end else begin
            fire = (phase == SET_ODD) || rq.stop;
            phase = (phase == SET_ODD) ? SET_EVEN : SET_ODD;
            window[0] = window[1];
            window[1] = window[2];
            window[2] = window[3];
            window[3] = pt;
         end
         if (fire) begin
            added = 0;
            if (rq.style[STYLE_OUTLINE]) begin
               if (rq.style[STYLE_FILL]) begin
                  if (rq.style[STYLE_INLINE]) add_primitive(4, 0, 2, 3, 1);
                  else if (rq.style[STYLE_INNER]) add_primitive(3, 0, 2, 3);
                  else if (rq.style[STYLE_DIAGONAL]) add_primitive(3, 0, 2, 1);
                  else add_primitive(3, 0, 2, 3);
               end else begin
                  add_primitive(2, 0, 2);
                  if (rq.style[STYLE_INLINE]) add_primitive(2, 3, 1);
                  if (rq.style[STYLE_INNER]) add_primitive(2, 1, 2);
                  if (rq.style[STYLE_DIAGONAL]) add_primitive(2, 0, 3);
                  if (rq.style[STYLE_RADIAL]) begin
                     add_primitive(2, 0, 1);
                     add_primitive(2, 2, 3);
                  end
               end
            end else if (rq.style[STYLE_RADIAL]) begin
               add_primitive(2, 0, 1);
            end else begin
               add_primitive(1, 0);
            end
            if (added > 0) expected[expected.size()-1].run_last = 1'b1;
         end
         if (rq.stop) phase = SET_IDLE;
      endfunction

      function void complain(string what, longint want, longint got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("primitive %0d: %s expected %0h, got %0h", results_seen, what, want, got);
      endfunction

      function void check_result(prim_type got);
         prim_type want;
         int       i;
         results_seen++;
         if (expected.size() == 0) begin
            complain("unexpected primitive, vertex_count", 0, longint'(got.vertex_count));
            return;
         end
         want = expected.pop_front();
         if (got.vertex_count !== want.vertex_count)
            complain("vertex_count", longint'(want.vertex_count), longint'(got.vertex_count));
         for (i = 0; i < NUM_SLOTS; i++) begin
            if (got.vx[i] !== want.vx[i])
               complain($sformatf("v%0d_x", i), longint'(want.vx[i]), longint'(got.vx[i]));
            if (got.vy[i] !== want.vy[i])
               complain($sformatf("v%0d_y", i), longint'(want.vy[i]), longint'(got.vy[i]));
         end
         if (got.color !== want.color)
            complain("color_out", longint'(want.color), longint'(got.color));
         if (got.run_last !== want.run_last)
            complain("run_last", longint'(want.run_last), longint'(got.run_last));
      endfunction

      function int pending();
         return expected.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic signed [IN_BITS-1:0]  req_x_coord = '0;
   logic signed [IN_BITS-1:0]  req_y_coord = '0;
   logic                       req_set_start = 1'b0;
   logic                       req_set_end = 1'b0;
   logic [STYLE_BITS-1:0]      req_style_bits = '0;
   logic [COLOR_BITS-1:0]      req_color_in = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [VCNT_BITS-1:0]       rsp_vertex_count;
   logic signed [OUT_BITS-1:0] rsp_v0_x;
   logic signed [OUT_BITS-1:0] rsp_v0_y;
   logic signed [OUT_BITS-1:0] rsp_v1_x;
   logic signed [OUT_BITS-1:0] rsp_v1_y;
   logic signed [OUT_BITS-1:0] rsp_v2_x;
   logic signed [OUT_BITS-1:0] rsp_v2_y;
   logic signed [OUT_BITS-1:0] rsp_v3_x;
   logic signed [OUT_BITS-1:0] rsp_v3_y;
   logic [COLOR_BITS-1:0]      rsp_color_out;
   logic                       rsp_run_last;
   logic                       csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [DIM_BITS-1:0]        csr_wdata = '0;

   stroke_scoreboard_type sb = new();
   bit                    calm = 1'b0;
   int                    receiver_hold = 0;
   int                    cycle_count = 0;

   stroke_primitive_assembler dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_x_coord      (req_x_coord),
      .req_y_coord      (req_y_coord),
      .req_set_start    (req_set_start),
      .req_set_end      (req_set_end),
      .req_style_bits   (req_style_bits),
      .req_color_in     (req_color_in),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_vertex_count (rsp_vertex_count),
      .rsp_v0_x         (rsp_v0_x),
      .rsp_v0_y         (rsp_v0_y),
      .rsp_v1_x         (rsp_v1_x),
      .rsp_v1_y         (rsp_v1_y),
      .rsp_v2_x         (rsp_v2_x),
      .rsp_v2_y         (rsp_v2_y),
      .rsp_v3_x         (rsp_v3_x),
      .rsp_v3_y         (rsp_v3_y),
      .rsp_color_out    (rsp_color_out),
      .rsp_run_last     (rsp_run_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_stroke_primitive_assembler: FAIL");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // A coordinate a little around the visible range, with random fraction bits.
   function automatic int pick_coord(int limit);
      int v;
      v = $urandom_range(0, limit + 31);
      v = (v - 16) * 16 + int'($urandom_range(0, 15)) - 8;
      if (v > 524287) v = 524287;
      if (v < -524288) v = -524288;
      return v;
   endfunction

   task automatic push_point(int x, int y,
                             logic start, logic stop, logic [STYLE_BITS-1:0] style,
                             logic [COLOR_BITS-1:0] color);
      point_request_type rq;
      int                gap;
      rq.x = IN_BITS'(x);
      rq.y = IN_BITS'(y);
      rq.start = start;
      rq.stop = stop;
      rq.style = style;
      rq.color = color;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_x_coord <= IN_BITS'(x);
      req_y_coord <= IN_BITS'(y);
      req_set_start <= start;
      req_set_end <= stop;
      req_style_bits <= style;
      req_color_in <= color;
      do @(posedge clock); while (req_full);
      sb.note_request(rq);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_register(idx, value);
   endtask

   task automatic configure(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                            logic [DIM_BITS-1:0] swap_word);
      write_register(CSR_SCREEN_WIDTH, w);
      write_register(CSR_SCREEN_HEIGHT, h);
      write_register(CSR_COLOR_BYTE_SWAP, swap_word);
      write_register(CSR_SPARE_INDEX, DIM_BITS'($urandom));
      csr_write <= 1'b0;
   endtask

   task automatic random_points(int count);
      int                    left;
      int                    len;
      int                    k;
      int                    r;
      logic [STYLE_BITS-1:0] style;
      logic [COLOR_BITS-1:0] color;
      int                    x;
      int                    y;
      left = count;
      x = pick_coord(int'(sb.screen_w));
      y = pick_coord(int'(sb.screen_h));
      while (left > 0) begin
         calm = ($urandom_range(0, 3) == 0);
         style = STYLE_BITS'($urandom_range(0, 63));
         color = $urandom;
         if ($urandom_range(0, 9) < 8) begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len && left > 0; k++) begin
               if ($urandom_range(0, 9) == 0) style = STYLE_BITS'($urandom_range(0, 63));
               r = $urandom_range(0, 19);
               if (r == 0) begin
                  x = int'($urandom);
                  y = int'($urandom);
               end else if (r > 2) begin
                  x = pick_coord(int'(sb.screen_w));
                  y = pick_coord(int'(sb.screen_h));
               end
               push_point(x, y, k == 0, k == len - 1, style, color);
               left--;
            end
         end else begin
            x = pick_coord(int'(sb.screen_w));
            y = pick_coord(int'(sb.screen_h));
            push_point(x, y, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), style, color);
            left--;
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      int       pop_wait;
      prim_type got;
      pop_wait = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.vertex_count = rsp_vertex_count;
            got.vx[0] = rsp_v0_x;
            got.vy[0] = rsp_v0_y;
            got.vx[1] = rsp_v1_x;
            got.vy[1] = rsp_v1_y;
            got.vx[2] = rsp_v2_x;
            got.vy[2] = rsp_v2_y;
            got.vx[3] = rsp_v3_x;
            got.vy[3] = rsp_v3_y;
            got.color = rsp_color_out;
            got.run_last = rsp_run_last;
            sb.check_result(got);
            pop_wait = pick_gap();
         end
         if (receiver_hold > 0) begin
            receiver_hold--;
            rsp_pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // A closed four-point set drawn as a quad.
      push_point(16 * 10, 16 * 10, 1'b1, 1'b0, M_OUTLINE | M_FILL | M_INLINE, 32'h11223344);
      push_point(16 * 100, 16 * 10, 1'b0, 1'b0, M_OUTLINE | M_FILL | M_INLINE, 32'h11223344);
      push_point(16 * 100, 16 * 100, 1'b0, 1'b0, M_OUTLINE | M_FILL | M_INLINE, 32'h11223344);
      push_point(16 * 10, 16 * 100, 1'b0, 1'b1, M_OUTLINE | M_FILL | M_INLINE, 32'h11223344);
      // A set opened without a start mark, closed on an odd point, all six lines.
      push_point(16 * 20, 16 * 20, 1'b0, 1'b0,
                 M_OUTLINE | M_INLINE | M_INNER | M_DIAGONAL | M_RADIAL, 32'hA5C30F96);
      push_point(16 * 30, 16 * 40, 1'b0, 1'b0,
                 M_OUTLINE | M_INLINE | M_INNER | M_DIAGONAL | M_RADIAL, 32'hA5C30F96);
      push_point(16 * 50, 16 * 60, 1'b0, 1'b1,
                 M_OUTLINE | M_INLINE | M_INNER | M_DIAGONAL | M_RADIAL, 32'hA5C30F96);
      // Saturating extremes and rounding of halves in both directions.
      push_point(-524288, 524287, 1'b1, 1'b0, M_OUTLINE | M_FILL, 32'hFFFFFFFF);
      push_point(524287, -524288, 1'b0, 1'b0, M_OUTLINE | M_FILL, 32'hFFFFFFFF);
      push_point(8, 24, 1'b0, 1'b0, M_OUTLINE | M_FILL, 32'hFFFFFFFF);
      push_point(-8, 7, 1'b0, 1'b0, M_OUTLINE | M_FILL, 32'hFFFFFFFF);
      push_point(16 * 5, 16 * 5, 1'b0, 1'b0, '0, 32'hFFFFFFFF);
      push_point(16 * 6, 16 * 6, 1'b0, 1'b1, M_RADIAL, 32'hFFFFFFFF);
      // Repeated points merge down to a single vertex.
      push_point(16 * 200, 16 * 200, 1'b1, 1'b0, M_OUTLINE | M_FILL | M_DIAGONAL, 32'h0);
      push_point(16 * 200, 16 * 200, 1'b0, 1'b0, M_OUTLINE | M_FILL | M_DIAGONAL, 32'h0);
      push_point(16 * 200, 16 * 200, 1'b0, 1'b0, M_OUTLINE | M_FILL | M_DIAGONAL, 32'h0);
      push_point(16 * 210, 16 * 200, 1'b0, 1'b1, M_OUTLINE | M_FILL | M_DIAGONAL, 32'h0);
      // A start mark inside an open set abandons it.
      push_point(16 * 300, 16 * 300, 1'b1, 1'b0, M_OUTLINE | M_FILL | M_INNER, 32'h0F1E2D3C);
      push_point(16 * 300, 16 * 301, 1'b1, 1'b0, M_OUTLINE | M_FILL | M_INNER, 32'h0F1E2D3C);
      push_point(16 * 310, 16 * 310, 1'b0, 1'b0, M_OUTLINE | M_FILL | M_INNER, 32'h0F1E2D3C);
      push_point(16 * 320, 16 * 320, 1'b0, 1'b1, M_OUTLINE | M_FILL | M_INNER, 32'h0F1E2D3C);
      // A one-point set, then a three-point set drawn as a single point.
      push_point(16 * 1, 16 * 1, 1'b1, 1'b1, M_OUTLINE, 32'h89ABCDEF);
      push_point(16 * 2, 16 * 2, 1'b1, 1'b0, '0, 32'h89ABCDEF);
      push_point(16 * 3, 16 * 3, 1'b0, 1'b0, '0, 32'h89ABCDEF);
      push_point(16 * 4, 16 * 4, 1'b0, 1'b1, '0, 32'h89ABCDEF);
      drain();

      configure(15'd32767, 15'd32767, {14'($urandom), 1'b1});
      receiver_hold = 300;
      random_points(40);
      drain();

      configure(15'd1, 15'd1, {14'($urandom), 1'b0});
      random_points(25);
      drain();

      configure(15'd0, 15'd0, {14'($urandom), 1'b1});
      random_points(10);
      drain();

      configure(15'($urandom_range(64, 1000)), 15'($urandom_range(64, 1000)),
                {14'($urandom), 1'b1});
      random_points(45);
      drain();

      configure(RESET_SCREEN_WIDTH, RESET_SCREEN_HEIGHT, {14'($urandom), 1'b0});
      random_points(20);
      drain();

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb_stroke_primitive_assembler: PASS");
      end else begin
         $display("tb_stroke_primitive_assembler: FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/spa_pkg.sv
design/spa_front.sv
design/spa_job_queue.sv
design/spa_back.sv
design/stroke_primitive_assembler.sv
dv/tb_stroke_primitive_assembler.sv
